// ===== rtl/spectral_bin_mask_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Spectral bin mask filter: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_BIN_MASK_FILTER_UNIT_DEFINES_SVH
`define SPECTRAL_BIN_MASK_FILTER_UNIT_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SBMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge
`define SBMF_NEVER(label, cond, msg) \
  `SBMF_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/sbmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmf_pkg
// Shared widths, codes, queue item type and ramp clamp for the bin mask filter.
// ----------------------------------------------------------------------------
package sbmf_pkg;

  localparam int MAX_BINS   = 4096;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int SAMPLE_W   = 32;
  localparam int STEP_W     = 17;
  localparam int GAIN_W     = 18;             // up to three full segments
  localparam int RPROD_W    = BIN_W + STEP_W;
  localparam int MAG_W      = 64;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int FRAC_W     = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [GAIN_W-1:0] ONE_Q16  = GAIN_W'(65536);
  localparam logic [BIN_W-1:0]  BIN_LAST = BIN_W'(MAX_BINS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLIP     = 3'd0,
    MODE_THRESH   = 3'd1,
    MODE_HIGHPASS = 3'd2,
    MODE_LOWPASS  = 3'd3,
    MODE_NOTCH    = 3'd4,
    MODE_BANDPASS = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_EDGE_A   = 3'd1,
    REG_EDGE_B   = 3'd2,
    REG_EDGE_C   = 3'd3,
    REG_EDGE_D   = 3'd4,
    REG_STEP_LO  = 3'd5,
    REG_STEP_UP  = 3'd6,
    REG_THRESH   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } item_t;

  function automatic logic [GAIN_W-1:0] ramp_clamp(input logic [RPROD_W-1:0] p);
    ramp_clamp = (p > RPROD_W'(ONE_Q16)) ? ONE_Q16 : p[GAIN_W-1:0];
  endfunction

endpackage

// ===== rtl/spectral_bin_mask_filter_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; the 4-entry queue between the gain front end
// and the scaler covers the front end's two stages, so full only rises on stall.
// Reset (rst_ni low, asynchronous): queue and pipeline empty, registers to
// mode clip, edge_a 0, edges b/c/d 4095, ramp steps and threshold 0.
// ----------------------------------------------------------------------------
// spectral_bin_mask_filter_unit
// Frequency-domain mask: each complex bin is scaled by a mode-dependent gain.
// ----------------------------------------------------------------------------
module spectral_bin_mask_filter_unit import sbmf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [BIN_W-1:0]            bin_index_i,
  input  logic signed [SAMPLE_W-1:0]  re_in_i,
  input  logic signed [SAMPLE_W-1:0]  im_in_i,
  input  logic                        is_last_bin_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [SAMPLE_W-1:0]  re_out_o,
  output logic signed [SAMPLE_W-1:0]  im_out_o,
  output logic                        last_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  logic  q_wr, q_rd, q_empty;
  item_t q_wr_item, q_rd_item;

  assign cfg_ready_o = 1'b1;

  sbmf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .bin_index_i   (bin_index_i),
    .re_in_i       (re_in_i),
    .im_in_i       (im_in_i),
    .is_last_bin_i (is_last_bin_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_pop_i       (q_rd),
    .q_wr_o        (q_wr),
    .q_item_o      (q_wr_item)
  );

  sbmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .item_i  (q_wr_item),
    .rd_i    (q_rd),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  sbmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_rd_item),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .re_out_o   (re_out_o),
    .im_out_o   (im_out_o),
    .last_out_o (last_out_o)
  );

endmodule

// ===== rtl/sbmf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmf_queue
// Short queue of classified items between the gain front end and the scaler.
// ----------------------------------------------------------------------------
`include "spectral_bin_mask_filter_unit_defines.svh"

module sbmf_queue import sbmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t item_i,
  input  logic  rd_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (rd_i) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(wr_i) - QCNT_W'(rd_i);
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);

  `SBMF_NEVER(a_q_no_overflow, wr_i && !rd_i && cnt_q == QCNT_W'(QDEPTH), "queue overflow")
  `SBMF_NEVER(a_q_no_underflow, rd_i && cnt_q == '0, "queue read while empty")

endmodule

// ===== rtl/sbmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmf_front
// Register file, bin classification and gain build-up in two stages.
// ----------------------------------------------------------------------------
`include "spectral_bin_mask_filter_unit_defines.svh"

module sbmf_front import sbmf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [BIN_W-1:0]            bin_index_i,
  input  logic signed [SAMPLE_W-1:0]  re_in_i,
  input  logic signed [SAMPLE_W-1:0]  im_in_i,
  input  logic                        is_last_bin_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        q_pop_i,
  output logic                        q_wr_o,
  output item_t                       q_item_o
);

  // configuration
  logic [MODE_W-1:0]  mode_q;
  logic [BIN_W-1:0]   edge_a_q, edge_b_q, edge_c_q, edge_d_q;
  logic [STEP_W-1:0]  step_lo_q, step_up_q;
  logic [MAG_W-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CLIP;
      edge_a_q  <= '0;
      edge_b_q  <= BIN_LAST;
      edge_c_q  <= BIN_LAST;
      edge_d_q  <= BIN_LAST;
      step_lo_q <= '0;
      step_up_q <= '0;
      thr_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MODE:    mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_EDGE_A:  edge_a_q  <= cfg_data_i[BIN_W-1:0];
        REG_EDGE_B:  edge_b_q  <= cfg_data_i[BIN_W-1:0];
        REG_EDGE_C:  edge_c_q  <= cfg_data_i[BIN_W-1:0];
        REG_EDGE_D:  edge_d_q  <= cfg_data_i[BIN_W-1:0];
        REG_STEP_LO: step_lo_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_UP: step_up_q <= cfg_data_i[STEP_W-1:0];
        REG_THRESH:  thr_q     <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // credit count: items between the input and the queue read side
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign full_o = (cnt_q == QCNT_W'(QDEPTH));
  assign accept = push_i && !full_o;
  assign cnt_d  = cnt_q + QCNT_W'(accept) - QCNT_W'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // stage 1: input register
  logic                       s1_valid_q;
  logic [BIN_W-1:0]           s1_bin_q;
  logic signed [SAMPLE_W-1:0] s1_re_q, s1_im_q;
  logic                       s1_last_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bin_q  <= bin_index_i;
      s1_re_q   <= re_in_i;
      s1_im_q   <= im_in_i;
      s1_last_q <= is_last_bin_i;
    end
  end

  // stage 1 logic: squares, ramp products, range flags, threshold level
  logic [SAMPLE_W-1:0] abs_re, abs_im;
  logic [MAG_W-1:0]    sq_re, sq_im, lvl;
  logic [RPROD_W-1:0]  rlo_prod, rup_prod;
  logic [BIN_W-1:0]    diff_a, diff_c;
  logic                in_ab, in_cd, in_bc, lt_a, gt_b, ge_d;

  always_comb begin
    abs_re   = s1_re_q[SAMPLE_W-1] ? (~s1_re_q + SAMPLE_W'(1)) : s1_re_q;
    abs_im   = s1_im_q[SAMPLE_W-1] ? (~s1_im_q + SAMPLE_W'(1)) : s1_im_q;
    sq_re    = MAG_W'(abs_re) * MAG_W'(abs_re);
    sq_im    = MAG_W'(abs_im) * MAG_W'(abs_im);
    diff_a   = s1_bin_q - edge_a_q;
    diff_c   = s1_bin_q - edge_c_q;
    rlo_prod = RPROD_W'(diff_a) * RPROD_W'(step_lo_q);
    rup_prod = RPROD_W'(diff_c) * RPROD_W'(step_up_q);
    in_ab    = (s1_bin_q >= edge_a_q) && (s1_bin_q <= edge_b_q);
    in_cd    = (s1_bin_q >= edge_c_q) && (s1_bin_q <= edge_d_q);
    in_bc    = (s1_bin_q >= edge_b_q) && (s1_bin_q <= edge_c_q);
    lt_a     = s1_bin_q < edge_a_q;
    gt_b     = s1_bin_q > edge_b_q;
    ge_d     = s1_bin_q >= edge_d_q;
    // DC and Nyquist bins use the full level, the rest a quarter rounded up
    if (s1_bin_q == '0 || s1_last_q) begin
      lvl = thr_q;
    end else begin
      lvl = {2'b00, thr_q[MAG_W-1:2]} + MAG_W'(|thr_q[1:0]);
    end
  end

  // stage 2 registers
  logic                       s2_valid_q;
  logic [MAG_W-1:0]           s2_sq_re_q, s2_sq_im_q, s2_lvl_q;
  logic [RPROD_W-1:0]         s2_rlo_q, s2_rup_q;
  logic                       s2_in_ab_q, s2_in_cd_q, s2_in_bc_q;
  logic                       s2_lt_a_q, s2_gt_b_q, s2_ge_d_q;
  logic signed [SAMPLE_W-1:0] s2_re_q, s2_im_q;
  logic                       s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_sq_re_q <= sq_re;
      s2_sq_im_q <= sq_im;
      s2_lvl_q   <= lvl;
      s2_rlo_q   <= rlo_prod;
      s2_rup_q   <= rup_prod;
      s2_in_ab_q <= in_ab;
      s2_in_cd_q <= in_cd;
      s2_in_bc_q <= in_bc;
      s2_lt_a_q  <= lt_a;
      s2_gt_b_q  <= gt_b;
      s2_ge_d_q  <= ge_d;
      s2_re_q    <= s1_re_q;
      s2_im_q    <= s1_im_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // stage 2 logic: overlapping segments add
  logic [MAG_W-1:0]  mag2;
  logic              pass;
  logic [GAIN_W-1:0] ramp_lo, ramp_up, gain;

  always_comb begin
    mag2    = s2_sq_re_q + s2_sq_im_q;
    pass    = mag2 >= s2_lvl_q;
    ramp_lo = ramp_clamp(s2_rlo_q);
    ramp_up = ramp_clamp(s2_rup_q);
    gain    = '0;
    case (mode_q)
      MODE_CLIP: begin
        if (s2_in_ab_q) gain = ONE_Q16;
      end
      MODE_THRESH: begin
        if (s2_in_ab_q && pass) gain = ONE_Q16;
      end
      MODE_HIGHPASS: begin
        gain = (s2_in_ab_q ? ramp_lo : '0) + (s2_gt_b_q ? ONE_Q16 : '0);
      end
      MODE_LOWPASS: begin
        gain = (s2_in_ab_q ? (ONE_Q16 - ramp_lo) : '0) + (s2_lt_a_q ? ONE_Q16 : '0);
      end
      MODE_NOTCH: begin
        gain = (s2_lt_a_q  ? ONE_Q16 : '0)
             + (s2_in_ab_q ? (ONE_Q16 - ramp_lo) : '0)
             + (s2_ge_d_q  ? ONE_Q16 : '0)
             + (s2_in_cd_q ? ramp_up : '0);
      end
      MODE_BANDPASS: begin
        gain = (s2_in_ab_q ? ramp_lo : '0)
             + (s2_in_cd_q ? (ONE_Q16 - ramp_up) : '0)
             + (s2_in_bc_q ? ONE_Q16 : '0);
      end
      default: gain = '0;
    endcase
  end

  assign q_wr_o        = s2_valid_q;
  assign q_item_o.gain = gain;
  assign q_item_o.re   = s2_re_q;
  assign q_item_o.im   = s2_im_q;
  assign q_item_o.last = s2_last_q;

  `SBMF_ASSERT(a_fe_credit_bound, cnt_q <= QCNT_W'(QDEPTH), "credit count above queue depth")
  `SBMF_NEVER(a_fe_pop_no_credit, q_pop_i && cnt_q == '0, "queue read with no item in flight")

endmodule

// ===== rtl/sbmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmf_back
// Scales each item by its gain, shifts by 16 and saturates; output register.
// ----------------------------------------------------------------------------
`include "spectral_bin_mask_filter_unit_defines.svh"

module sbmf_back import sbmf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  item_t                       q_item_i,
  output logic                        q_rd_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic signed [SAMPLE_W-1:0]  re_out_o,
  output logic signed [SAMPLE_W-1:0]  im_out_o,
  output logic                        last_out_o
);

  logic                     b1_valid_q, b2_valid_q;
  logic                     b1_ready, b2_ready;
  logic signed [PROD_W-1:0] b1_re_q, b1_im_q;
  logic                     b1_last_q;

  assign b2_ready = !b2_valid_q || pop_i;
  assign b1_ready = !b1_valid_q || b2_ready;
  assign q_rd_o   = !q_empty_i && b1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      if (b1_ready) b1_valid_q <= q_rd_o;
      if (b2_ready) b2_valid_q <= b1_valid_q;
    end
  end

  logic signed [GAIN_W:0] gain_s;
  assign gain_s = $signed({1'b0, q_item_i.gain});

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      b1_re_q   <= PROD_W'($signed(q_item_i.re) * gain_s);
      b1_im_q   <= PROD_W'($signed(q_item_i.im) * gain_s);
      b1_last_q <= q_item_i.last;
    end
  end

  // arithmetic shift floors, then clip to the sample range
  function automatic logic [SAMPLE_W-1:0] shift_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]     sh;
    logic [PROD_W-SAMPLE_W:0]     top;
    sh  = p >>> FRAC_W;
    top = sh[PROD_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      shift_sat = sh[SAMPLE_W-1:0];
    end else if (sh[PROD_W-1]) begin
      shift_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      shift_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (b2_ready && b1_valid_q) begin
      re_out_o   <= shift_sat(b1_re_q);
      im_out_o   <= shift_sat(b1_im_q);
      last_out_o <= b1_last_q;
    end
  end

  assign empty_o = !b2_valid_q;

  `SBMF_ASSERT(a_be_advance, (b1_valid_q && b2_ready) |=> b2_valid_q, "scaled item lost")

endmodule
